// ----- rtl/core/palexp_pkg.sv -----
package palexp_pkg;

   // Source image and palette geometry
   localparam int SRC_WIDTH       = 320;
   localparam int SRC_HEIGHT      = 200;
   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_SCALE       = 8;

   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // Distance of one entry: three squares of 8-bit differences, 16 bits each
   localparam int DIST_W = 18;

   // Command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_SCALE        = 2'd1;
   localparam logic [1:0] CSR_FB_WIDTH     = 2'd2;

   // Register reset values
   localparam logic        FMT_RESET   = 1'b1;
   localparam logic [3:0]  SCALE_RESET = 4'd1;
   localparam logic [12:0] FBW_RESET   = 13'd320;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_EMIT,
      ST_QUERY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] index;
      logic [8:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] color_red;
      logic [7:0] color_green;
      logic [7:0] color_blue;
   } req_type;

   typedef struct packed {
      logic [23:0] out_addr;
      logic [31:0] out_data;
      logic [7:0]  match_index;
      logic        status;
      logic        last;
   } rsp_type;

   // 8:8:8 color to 5:6:5
   function automatic logic [15:0] to_rgb565(input logic [23:0] rgb);
      return {rgb[23:19], rgb[15:10], rgb[7:3]};
   endfunction

endpackage

// ----- rtl/core/palette_expand_upscaler.sv -----
// Channel   | Ports                         | Moves
// ----------+-------------------------------+----------------------------------------
// request   | req_valid, req_stall, req_data| load / draw / query commands
// response  | rsp_valid, rsp_stall, rsp_data| framebuffer writes, query match, errors
// csr       | csr_we, csr_index, csr_wdata  | pixel_format, scale, fb_width
//
// One command at a time. Draw: one write per cycle while rsp_stall is low, once the
// base address is formed (palette read, two setup multiplies).
// Query: up to PALETTE_ENTRIES entries, one palette read per cycle through a
// three-stage read/square/compare pipeline; an exact match stops it early.
// Reset is synchronous; the palette valid bits clear in the same cycle, so the
// palette reads as zero right after reset with no clearing pass.
// rsp_stall holds the output register and the write sequencer waits on it.
module palette_expand_upscaler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  palexp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output palexp_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_wdata
);
   import palexp_pkg::*;

   // Configuration
   logic        fmt_ff;
   logic [3:0]  scale_ff;
   logic [12:0] fb_width_ff;

   // Control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;

   // Palette memory with per-entry valid bits
   logic [23:0]                pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [23:0]                pal_rdata_ff;
   logic                       pal_rvld_ff;
   logic [PAL_AW-1:0]          raddr;
   logic                       mem_we;

   // Handshake decode
   logic accept;
   logic out_free;
   logic emit_go;
   logic res_go;
   logic issue;

   // Draw datapath
   logic [3:0]  s_eff;
   logic [13:0] span;
   logic        too_wide;
   logic        pos_ok;
   logic        idx_ok;
   logic [3:0]  s_ff;
   logic [8:0]  px_ff;
   logic [7:0]  py_ff;
   logic        pal_hit_ff;
   logic [31:0] data_ff;
   logic [11:0] ys_ff;
   logic [15:0] xcol_ff;
   logic [23:0] row_ff;
   logic [23:0] cur_ff;
   logic [3:0]  dx_ff;
   logic [3:0]  dy_ff;
   logic [23:0] pix_rgb;
   logic [13:0] xdiff;
   logic [14:0] xoff;
   logic [12:0] xs;
   logic [14:0] xs_bytes;
   logic [14:0] stride;
   logic [26:0] row_prod;
   logic [23:0] step_bpp;
   logic        last_px;

   // Query pipeline
   logic [7:0]        q_red_ff;
   logic [7:0]        q_green_ff;
   logic [7:0]        q_blue_ff;
   logic [PAL_AW:0]   scan_cnt_ff;
   logic              scan_more;
   logic              a_vld_ff;
   logic [PAL_AW-1:0] a_idx_ff;
   logic              b_vld_ff;
   logic [PAL_AW-1:0] b_idx_ff;
   logic [15:0]       sq_r_ff;
   logic [15:0]       sq_g_ff;
   logic [15:0]       sq_b_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [PAL_AW-1:0] best_idx_ff;
   logic [23:0]       entry_a;
   logic [7:0]        er, eg, eb;
   logic [DIST_W-1:0] dist_sum;
   logic              better;
   logic              scan_done;
   logic [PAL_AW-1:0] match_c;

   // Single-result payload
   logic [7:0] res_match_ff;
   logic       res_status_ff;

   // Command checks on the incoming transaction
   always_comb begin
      if (scale_ff == 4'd0) begin
         s_eff = 4'd1;
      end else if (scale_ff > 4'(MAX_SCALE)) begin
         s_eff = 4'(MAX_SCALE);
      end else begin
         s_eff = scale_ff;
      end
      span     = 14'(SRC_WIDTH) * {10'd0, s_eff};
      too_wide = span > {1'b0, fb_width_ff};
      pos_ok   = (11'(req_data.pos_x) < 11'(SRC_WIDTH)) &&
                 (11'(req_data.pos_y) < 11'(SRC_HEIGHT));
      idx_ok   = {1'b0, req_data.index} < 9'(PALETTE_ENTRIES);
   end

   // Query difference and compare stages
   always_comb begin
      entry_a   = pal_rvld_ff ? pal_rdata_ff : 24'd0;
      er        = (q_red_ff >= {3'd0, entry_a[23:19]}) ? q_red_ff - {3'd0, entry_a[23:19]}
                                                     : {3'd0, entry_a[23:19]} - q_red_ff;
      eg        = (q_green_ff >= {2'd0, entry_a[15:10]}) ? q_green_ff - {2'd0, entry_a[15:10]}
                                                       : {2'd0, entry_a[15:10]} - q_green_ff;
      eb        = (q_blue_ff >= {3'd0, entry_a[7:3]}) ? q_blue_ff - {3'd0, entry_a[7:3]}
                                                    : {3'd0, entry_a[7:3]} - q_blue_ff;
      dist_sum  = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      better    = b_vld_ff && (dist_sum < best_d_ff);
      scan_done = b_vld_ff && ((dist_sum == '0) ||
                               (b_idx_ff == PAL_AW'(PALETTE_ENTRIES - 1)));
      match_c   = better ? b_idx_ff : best_idx_ff;
      scan_more = scan_cnt_ff < (PAL_AW + 1)'(PALETTE_ENTRIES);
   end

   // Draw address arithmetic
   always_comb begin
      pix_rgb  = (pal_rvld_ff && pal_hit_ff) ? pal_rdata_ff : 24'd0;
      xdiff    = {1'b0, fb_width_ff} - 14'(SRC_WIDTH) * {10'd0, s_ff};
      xoff     = fmt_ff ? {xdiff, 1'b0} : {1'b0, xdiff};
      xs       = 13'(px_ff) * 13'(s_ff);
      xs_bytes = fmt_ff ? {xs, 2'b00} : {1'b0, xs, 1'b0};
      stride   = fmt_ff ? {fb_width_ff, 2'b00} : {1'b0, fb_width_ff, 1'b0};
      row_prod = 27'(ys_ff) * 27'(stride);
      step_bpp = fmt_ff ? 24'd4 : 24'd2;
      last_px  = (dx_ff == s_ff - 4'd1) && (dy_ff == s_ff - 4'd1);
   end

   // Handshake and memory control decode
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit_go   = (state_ff == ST_EMIT) && out_free;
      res_go    = (state_ff == ST_RESULT) && out_free;
      issue     = (accept && (req_data.cmd == CMD_QUERY)) ||
                  ((state_ff == ST_QUERY) && scan_more && !scan_done);
      mem_we    = accept && (req_data.cmd == CMD_LOAD) && idx_ok;
      if (state_ff == ST_IDLE) begin
         raddr = (req_data.cmd == CMD_QUERY) ? '0 : req_data.index[PAL_AW-1:0];
      end else begin
         raddr = scan_cnt_ff[PAL_AW-1:0];
      end
      rsp_valid_in = (emit_go || res_go) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_DRAW: begin
                     if (too_wide) begin
                        state_in = ST_RESULT;
                     end else if (pos_ok) begin
                        state_in = ST_SETUP;
                     end
                  end
                  CMD_QUERY: state_in = ST_QUERY;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: state_in = ST_BASE;
         ST_BASE:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go && last_px) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (res_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pal_vld_ff   <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         fmt_ff       <= FMT_RESET;
         scale_ff     <= SCALE_RESET;
         fb_width_ff  <= FBW_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         a_vld_ff     <= issue;
         b_vld_ff     <= a_vld_ff && (state_ff == ST_QUERY) && !scan_done;
         if (mem_we) begin
            pal_vld_ff[req_data.index[PAL_AW-1:0]] <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PIXEL_FORMAT: fmt_ff      <= csr_wdata[0];
               CSR_SCALE:        scale_ff    <= csr_wdata[3:0];
               CSR_FB_WIDTH:     fb_width_ff <= csr_wdata;
               default:          ;
            endcase
         end
      end
   end

   // Palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pal_mem[req_data.index[PAL_AW-1:0]] <= {req_data.color_red, req_data.color_green,
                                                  req_data.color_blue};
      end
      pal_rdata_ff <= pal_mem[raddr];
      pal_rvld_ff  <= pal_vld_ff[raddr];
      a_idx_ff     <= raddr;
   end

   // Draw and query datapath
   always_ff @(posedge clock) begin
      // transaction capture
      if (accept) begin
         s_ff          <= s_eff;
         px_ff         <= req_data.pos_x;
         py_ff         <= req_data.pos_y;
         pal_hit_ff    <= idx_ok;
         q_red_ff      <= req_data.color_red;
         q_green_ff    <= req_data.color_green;
         q_blue_ff     <= req_data.color_blue;
         best_d_ff     <= '1;
         best_idx_ff   <= '0;
         scan_cnt_ff   <= (PAL_AW + 1)'(1);
         res_match_ff  <= 8'd0;
         res_status_ff <= 1'b1;
      end

      // palette word formatted, and row and column products
      if (state_ff == ST_SETUP) begin
         data_ff <= fmt_ff ? {8'd0, pix_rgb} : {16'd0, to_rgb565(pix_rgb)};
         ys_ff   <= 12'(py_ff) * 12'(s_ff);
         xcol_ff <= 16'(xs_bytes) + 16'(xoff);
      end

      // first address of the block
      if (state_ff == ST_BASE) begin
         row_ff <= row_prod[23:0] + 24'(xcol_ff);
         cur_ff <= row_prod[23:0] + 24'(xcol_ff);
         dx_ff  <= 4'd0;
         dy_ff  <= 4'd0;
      end

      // walk the scale x scale block, row by row
      if (emit_go) begin
         if (dx_ff == s_ff - 4'd1) begin
            dx_ff  <= 4'd0;
            dy_ff  <= dy_ff + 4'd1;
            row_ff <= row_ff + 24'(stride);
            cur_ff <= row_ff + 24'(stride);
         end else begin
            dx_ff  <= dx_ff + 4'd1;
            cur_ff <= cur_ff + step_bpp;
         end
      end

      // query pipeline: squares, then sum and compare
      if ((state_ff == ST_QUERY) && issue) begin
         scan_cnt_ff <= scan_cnt_ff + (PAL_AW + 1)'(1);
      end
      sq_r_ff  <= er * er;
      sq_g_ff  <= eg * eg;
      sq_b_ff  <= eb * eb;
      b_idx_ff <= a_idx_ff;
      if ((state_ff == ST_QUERY) && better) begin
         best_d_ff   <= dist_sum;
         best_idx_ff <= b_idx_ff;
      end
      if ((state_ff == ST_QUERY) && scan_done) begin
         res_match_ff  <= 8'(match_c);
         res_status_ff <= 1'b0;
      end

      // output register
      if (emit_go) begin
         rsp_ff.out_addr    <= cur_ff;
         rsp_ff.out_data    <= data_ff;
         rsp_ff.match_index <= 8'd0;
         rsp_ff.status      <= 1'b0;
         rsp_ff.last        <= last_px;
      end else if (res_go) begin
         rsp_ff.out_addr    <= 24'd0;
         rsp_ff.out_data    <= 32'd0;
         rsp_ff.match_index <= res_match_ff;
         rsp_ff.status      <= res_status_ff;
         rsp_ff.last        <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // No stale query entry survives the end of a scan
   a_scan_flush: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (state_ff == ST_QUERY))
      else $error("query pipeline entry outside a scan");

   // Block counters stay inside the scale window
   a_block_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((dx_ff < s_ff) && (dy_ff < s_ff)))
      else $error("draw counter past scale");

   // Error transactions carry no write
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (rsp_ff.last && (rsp_ff.out_addr == 24'd0)
                                           && (rsp_ff.out_data == 32'd0)))
      else $error("error transaction with payload");

   // Best distance only shrinks during a scan
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_QUERY) && ($past(state_ff) == ST_QUERY)) |->
         (best_d_ff <= $past(best_d_ff)))
      else $error("best distance grew");

endmodule
